// ===== rtl/rv64_eu_pkg.sv =====
package rv64_eu_pkg;

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_SUB = 6'd1, OP_AND = 6'd2, OP_OR = 6'd3, OP_XOR = 6'd4,
		OP_SLL = 6'd5, OP_SRL = 6'd6, OP_SRA = 6'd7, OP_ADDI = 6'd8, OP_ANDI = 6'd9,
		OP_ORI = 6'd10, OP_XORI = 6'd11, OP_SLLI = 6'd12, OP_SRLI = 6'd13,
		OP_SRAI = 6'd14, OP_LUI = 6'd15, OP_LD = 6'd16, OP_LW = 6'd17, OP_LH = 6'd18,
		OP_LB = 6'd19, OP_LWU = 6'd20, OP_LHU = 6'd21, OP_LBU = 6'd22, OP_SD = 6'd23,
		OP_SW = 6'd24, OP_SH = 6'd25, OP_SB = 6'd26, OP_BEQ = 6'd27, OP_BNE = 6'd28,
		OP_BLT = 6'd29, OP_BGE = 6'd30, OP_BLTU = 6'd31, OP_BGEU = 6'd32,
		OP_JAL = 6'd33, OP_JALR = 6'd34
	} op_t;

	typedef struct packed {
		logic        is_load;
		logic        is_store;
		logic [3:0]  size;
		logic        sext;
	} mem_req_t;

endpackage

// ===== rtl/rv64i_subset_execute_unit_core.sv =====
// Executes one pre-decoded RV64I-subset instruction per transfer. Each instruction first reads
// the register file (synchronous RAM, registered read), then executes, accesses data memory
// and writes back; a new instruction is not taken while one is in execute. Loads need an extra
// step for their data, because the memory address is only known in execute; the input is held
// off during that step. A result that waits on a stalled output holds the instruction behind
// it in execute, so one more instruction is taken while a result waits. Memory is MEM_BYTES
// bytes, little-endian, in 8-byte rows; x0 reads zero. No clearing pass: register reset is
// held with per-register valid bits, memory is undefined until written.
module rv64i_subset_execute_unit_core #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  operation,
	input  logic [4:0]  dest_index,
	input  logic [4:0]  src1_index,
	input  logic [4:0]  src2_index,
	input  logic signed [20:0] immediate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] executed_pc,
	output logic [31:0] next_pc,
	output logic        write_valid,
	output logic [4:0]  write_index,
	output logic signed [63:0] write_value,
	output logic        branch_taken,
	output logic        access_fault
);
	import rv64_eu_pkg::*;

	logic [63:0] rf_q [32];
	logic [31:0] rv_q;
	logic [31:0] pc_q;
	logic busy_s1;
	logic [5:0] op_s1;
	logic [4:0] rd_s1, r1_s1, r2_s1;
	logic [63:0] imm_s1;
	logic [63:0] ra_q, rb_q;
	logic take;
	logic go;
	logic [63:0] a, b, val, addr;
	logic [31:0] npc;
	logic wr, tk, flt, c;
	logic [5:0] sh;
	logic [63:0] sgn;
	mem_req_t mreq;
	logic mfault;
	logic [63:0] mdata;
	logic [31:0] lui_v;
	logic ld_pend_q;
	logic [4:0] ld_rd_q;
	logic ld_go;

	assign in_stall = busy_s1 || ld_pend_q;
	assign take = in_valid && !in_stall;
	assign go = busy_s1 && !(out_valid && out_stall);

	// Load data lands in the register file in the cycle after execute; the input side is held
	// off during that cycle so the next read sees it.
	always_ff @(posedge clk) begin
		if (take) begin
			ra_q <= rf_q[src1_index];
			rb_q <= rf_q[src2_index];
			op_s1 <= operation;
			rd_s1 <= dest_index;
			r1_s1 <= src1_index;
			r2_s1 <= src2_index;
			imm_s1 <= {{43{immediate[20]}}, immediate};
		end
		if (go && wr) rf_q[rd_s1] <= val;
		else if (ld_pend_q) rf_q[ld_rd_q] <= mdata;
	end

	assign a = rv_q[r1_s1] ? ra_q : 64'd0;
	assign b = rv_q[r2_s1] ? rb_q : 64'd0;
	assign addr = a + imm_s1;
	assign sgn = 64'h8000000000000000;
	assign lui_v = {imm_s1[19:0], 12'd0};

	always_comb begin
		mreq = '0;
		mreq.size = 4'd8;
		unique case (op_t'(op_s1))
			OP_LD: begin mreq.is_load = 1'b1; mreq.size = 4'd8; end
			OP_LW: begin mreq.is_load = 1'b1; mreq.size = 4'd4; mreq.sext = 1'b1; end
			OP_LH: begin mreq.is_load = 1'b1; mreq.size = 4'd2; mreq.sext = 1'b1; end
			OP_LB: begin mreq.is_load = 1'b1; mreq.size = 4'd1; mreq.sext = 1'b1; end
			OP_LWU: begin mreq.is_load = 1'b1; mreq.size = 4'd4; end
			OP_LHU: begin mreq.is_load = 1'b1; mreq.size = 4'd2; end
			OP_LBU: begin mreq.is_load = 1'b1; mreq.size = 4'd1; end
			OP_SD: begin mreq.is_store = 1'b1; mreq.size = 4'd8; end
			OP_SW: begin mreq.is_store = 1'b1; mreq.size = 4'd4; end
			OP_SH: begin mreq.is_store = 1'b1; mreq.size = 4'd2; end
			OP_SB: begin mreq.is_store = 1'b1; mreq.size = 4'd1; end
			default: ;
		endcase
	end

	// Memory address is only known after the register read, so the load is issued in the
	// execute cycle and its data arrives in the following cycle, where the result is formed.
	rv64_eu_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk(clk), .arst_n(arst_n), .req_valid(go), .req(mreq), .addr(addr),
		.wdata(b), .fault(mfault), .rdata(mdata)
	);

	always_comb begin
		sh = op_s1 <= 6'(OP_SRA) ? b[5:0] : imm_s1[5:0];
		val = '0; wr = 1'b0; tk = 1'b0; flt = 1'b0; c = 1'b0;
		npc = pc_q + 32'd4;
		unique case (op_t'(op_s1))
			OP_ADD: val = a + b;
			OP_SUB: val = a - b;
			OP_AND: val = a & b;
			OP_OR: val = a | b;
			OP_XOR: val = a ^ b;
			OP_SLL, OP_SLLI: val = a << sh;
			OP_SRL, OP_SRLI: val = a >> sh;
			OP_SRA, OP_SRAI: val = 64'($signed(a) >>> sh);
			OP_ADDI: val = addr;
			OP_ANDI: val = a & imm_s1;
			OP_ORI: val = a | imm_s1;
			OP_XORI: val = a ^ imm_s1;
			OP_LUI: val = {{32{lui_v[31]}}, lui_v};
			OP_LD, OP_LW, OP_LH, OP_LB, OP_LWU, OP_LHU, OP_LBU,
			OP_SD, OP_SW, OP_SH, OP_SB: flt = mfault;
			OP_BEQ: c = (a == b);
			OP_BNE: c = (a != b);
			OP_BLT: c = ((a ^ sgn) < (b ^ sgn));
			OP_BGE: c = ((a ^ sgn) >= (b ^ sgn));
			OP_BLTU: c = (a < b);
			OP_BGEU: c = (a >= b);
			OP_JAL: begin val = {32'd0, pc_q + 32'd4}; tk = 1'b1; npc = pc_q + imm_s1[31:0]; end
			OP_JALR: begin val = {32'd0, pc_q + 32'd4}; tk = 1'b1; npc = {addr[31:1], 1'b0}; end
			default: ;
		endcase
		if (op_s1 <= 6'(OP_LUI) || op_s1 == 6'(OP_JAL) || op_s1 == 6'(OP_JALR)) wr = 1'b1;
		if (c) begin tk = 1'b1; npc = pc_q + imm_s1[31:0]; end
		if (rd_s1 == 5'd0) wr = 1'b0;
		if (!wr) val = '0;
	end

	assign ld_go = go && mreq.is_load && !mfault && (rd_s1 != 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			pc_q <= '0;
			rv_q <= '0;
			out_valid <= 1'b0;
			ld_pend_q <= 1'b0;
			ld_rd_q <= '0;
			executed_pc <= '0;
			next_pc <= '0;
			write_valid <= 1'b0;
			write_index <= '0;
			write_value <= '0;
			branch_taken <= 1'b0;
			access_fault <= 1'b0;
		end else begin
			out_valid <= ld_pend_q || (go && !ld_go) || (out_valid && out_stall);
			ld_pend_q <= ld_go;
			busy_s1 <= take || (busy_s1 && !go);
			if (ld_pend_q) begin
				write_value <= mdata;
				rv_q[ld_rd_q] <= 1'b1;
			end else if (go) begin
				pc_q <= npc;
				if (wr) rv_q[rd_s1] <= 1'b1;
				executed_pc <= pc_q;
				next_pc <= npc;
				write_valid <= wr || ld_go;
				write_index <= (wr || ld_go) ? rd_s1 : 5'd0;
				write_value <= val;
				branch_taken <= tk;
				access_fault <= flt;
				ld_rd_q <= rd_s1;
			end
		end
	end
endmodule

// ===== rtl/rv64_eu_mem.sv =====
module rv64_eu_mem #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  rv64_eu_pkg::mem_req_t req,
	input  logic [63:0] addr,
	input  logic [63:0] wdata,
	output logic        fault,
	output logic [63:0] rdata
);
	import rv64_eu_pkg::*;

	localparam int LW = $clog2(MEM_BYTES / 8);

	logic [7:0] mem_q [MEM_BYTES / 8][8];
	logic [LW-1:0] row_lo, row_hi;
	logic [2:0] off;
	logic [63:0] rd_lo_q, rd_hi_q;
	logic [2:0] off_s1;
	logic [3:0] size_s1;
	logic sext_s1;
	logic [127:0] pair;
	logic [63:0] raw;
	logic [15:0] bmask;
	logic [127:0] wshift;

	assign off = addr[2:0];
	assign row_lo = addr[LW+2:3];
	assign row_hi = row_lo + LW'(1);
	assign fault = (addr > 64'(MEM_BYTES) - 64'(req.size));
	assign bmask = ({12'd0, req.size} == 16'd8) ? (16'h00ff << off) :
		(16'(((17'd1 << req.size) - 17'd1)) << off);
	assign wshift = {64'd0, wdata} << {off, 3'd0};

	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			rd_lo_q[8*k +: 8] <= mem_q[row_lo][k];
			rd_hi_q[8*k +: 8] <= mem_q[row_hi][k];
		end
		if (req_valid && req.is_store && !fault) begin
			for (int k = 0; k < 8; k++) begin
				if (bmask[k]) mem_q[row_lo][k] <= wshift[8*k +: 8];
				if (bmask[k+8]) mem_q[row_hi][k] <= wshift[64+8*k +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_s1 <= '0;
			size_s1 <= 4'd8;
			sext_s1 <= 1'b0;
		end else if (req_valid) begin
			off_s1 <= off;
			size_s1 <= req.size;
			sext_s1 <= req.sext;
		end
	end

	assign pair = {rd_hi_q, rd_lo_q} >> {off_s1, 3'd0};
	assign raw = pair[63:0];

	always_comb begin
		unique case (size_s1)
			4'd1: rdata = sext_s1 ? {{56{raw[7]}}, raw[7:0]} : {56'd0, raw[7:0]};
			4'd2: rdata = sext_s1 ? {{48{raw[15]}}, raw[15:0]} : {48'd0, raw[15:0]};
			4'd4: rdata = sext_s1 ? {{32{raw[31]}}, raw[31:0]} : {32'd0, raw[31:0]};
			default: rdata = raw;
		endcase
	end
endmodule
